[rtl/core/scct_pkg.sv]
package scct_pkg;

   localparam int TAG_W    = 32;
   localparam int OUT_IDX_W = 6;
   localparam int REL_W    = 6;

   // request kinds carried on tuser
   localparam logic [1:0] KIND_ACCESS      = 2'd0;
   localparam logic [1:0] KIND_RELEASE     = 2'd1;
   localparam logic [1:0] KIND_FLUSH       = 2'd2;
   localparam logic [1:0] KIND_FLUSH_CLEAR = 2'd3;

   typedef struct packed {
      logic                 no_victim;
      logic [TAG_W-1:0]     writeback_sector;
      logic                 writeback_valid;
      logic [TAG_W-1:0]     fill_sector;
      logic                 fill_valid;
      logic                 hit;
      logic [OUT_IDX_W-1:0] entry_index;
   } rsp_type;

endpackage

[rtl/core/scct_ram.sv]
module scct_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data between reads
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[rtl/core/sector_cache_clock_tags_core.sv]
// Tag and state table of a fully associative sector cache with clock
// (second chance) replacement. Tag, pin count, dirty and accessed marks of
// every entry live in one RAM with a single read port; valid bits are flops.
// Each walk over the table visits one entry at a time (read, then
// evaluate and write back). An access walks the whole table for the
// lookup, then its decision waits while a result beat is still held on
// the output, and, when the table is full and a victim must be chosen, a
// second walk clears accessed marks. A release reads its entry, then
// lowers its pin count. A flush walks the table, waiting on result stalls.
// Flush results come out in index order, tlast on the final one; a flush
// with nothing dirty returns no beat. A release returns no beat.
module sector_cache_clock_tags_core #(
   parameter int ENTRIES  = 64,
   parameter int PIN_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // sector[31:0], write_intent[32], release_index[38:33], zero[39]
   input  logic [39:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // entry_index[5:0], hit[6], fill_valid[7], fill_sector[39:8],
   // writeback_valid[40], writeback_sector[72:41], no_victim[73], zero[79:74]
   output logic [79:0] rsp_tdata,
   output logic        rsp_tlast
);

   import scct_pkg::*;

   localparam int IW     = $clog2(ENTRIES);
   localparam int CW     = $clog2(ENTRIES + 1);
   localparam int PIN_LO = TAG_W;
   localparam int DRT_B  = TAG_W + PIN_BITS;
   localparam int ACC_B  = TAG_W + PIN_BITS + 1;
   localparam int WW     = TAG_W + PIN_BITS + 2;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_LK_RD  = 4'd1;
   localparam logic [3:0] S_LK_EV  = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_CS_RD  = 4'd4;
   localparam logic [3:0] S_CS_EV  = 4'd5;
   localparam logic [3:0] S_REL_EV = 4'd6;
   localparam logic [3:0] S_FL_RD  = 4'd7;
   localparam logic [3:0] S_FL_EV  = 4'd8;
   localparam logic [3:0] S_FL_END = 4'd9;

   logic [3:0]         state_ff, state_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      limit_ff, limit_in;
   logic [TAG_W-1:0]   sector_ff, sector_in;
   logic               wr_ff, wr_in;
   logic               clear_ff, clear_in;
   logic [IW-1:0]      rel_ff, rel_in;
   logic               hit_f_ff, hit_f_in;
   logic [IW-1:0]      hit_idx_ff, hit_idx_in;
   logic [WW-1:0]      hit_word_ff, hit_word_in;
   logic               free_f_ff, free_f_in;
   logic [IW-1:0]      free_idx_ff, free_idx_in;
   logic               unp_f_ff, unp_f_in;
   logic [IW-1:0]      unp_idx_ff, unp_idx_in;
   logic [WW-1:0]      unp_word_ff, unp_word_in;
   logic               clr_f_ff, clr_f_in;
   logic [IW-1:0]      clr_idx_ff, clr_idx_in;
   logic [WW-1:0]      clr_word_ff, clr_word_in;
   logic [IW-1:0]      victim_ff, victim_in;
   logic               pend_v_ff, pend_v_in;
   logic [IW-1:0]      pend_idx_ff, pend_idx_in;
   logic [TAG_W-1:0]   pend_tag_ff, pend_tag_in;
   logic               out_v_ff, out_v_in;
   logic               out_last_ff, out_last_in;
   rsp_type            out_ff, out_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;

   logic               ram_wr_en, ram_rd_en;
   logic [IW-1:0]      ram_wr_addr, ram_rd_addr;
   logic [WW-1:0]      ram_wr_data, rd_word, vword;
   logic [IW-1:0]      idx;
   logic               cur_valid, out_free, idx_last;
   logic [PIN_BITS-1:0] cur_pin;

   scct_ram #(.WIDTH(WW), .DEPTH(ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_word)
   );

   assign idx       = idx_ff[IW-1:0];
   assign idx_last  = (idx_ff == CW'(ENTRIES - 1));
   assign cur_valid = valid_ff[idx];
   assign cur_pin   = rd_word[DRT_B-1:PIN_LO];
   assign out_free  = !out_v_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      limit_in    = limit_ff;
      sector_in   = sector_ff;
      wr_in       = wr_ff;
      clear_in    = clear_ff;
      rel_in      = rel_ff;
      hit_f_in    = hit_f_ff;
      hit_idx_in  = hit_idx_ff;
      hit_word_in = hit_word_ff;
      free_f_in   = free_f_ff;
      free_idx_in = free_idx_ff;
      unp_f_in    = unp_f_ff;
      unp_idx_in  = unp_idx_ff;
      unp_word_in = unp_word_ff;
      clr_f_in    = clr_f_ff;
      clr_idx_in  = clr_idx_ff;
      clr_word_in = clr_word_ff;
      victim_in   = victim_ff;
      pend_v_in   = pend_v_ff;
      pend_idx_in = pend_idx_ff;
      pend_tag_in = pend_tag_ff;
      out_v_in    = out_v_ff && !rsp_tready;
      out_last_in = out_last_ff;
      out_in      = out_ff;
      valid_in    = valid_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx;
      ram_wr_data = rd_word;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx;
      vword       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               sector_in = req_tdata[31:0];
               wr_in     = req_tdata[32];
               rel_in    = IW'(req_tdata[38:33]);
               clear_in  = (req_tuser == KIND_FLUSH_CLEAR);
               idx_in    = '0;
               hit_f_in  = 1'b0;
               free_f_in = 1'b0;
               unp_f_in  = 1'b0;
               clr_f_in  = 1'b0;
               pend_v_in = 1'b0;
               priority case (req_tuser)
                  KIND_ACCESS: state_in = S_LK_RD;
                  KIND_RELEASE: begin
                     if (32'(req_tdata[38:33]) < ENTRIES) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = IW'(req_tdata[38:33]);
                        state_in    = S_REL_EV;
                     end
                  end
                  default: state_in = S_FL_RD;
               endcase
            end
         end
         S_LK_RD: begin
            ram_rd_en = 1'b1;
            state_in  = S_LK_EV;
         end
         S_LK_EV: begin
            if (cur_valid && rd_word[TAG_W-1:0] == sector_ff && !hit_f_ff) begin
               hit_f_in    = 1'b1;
               hit_idx_in  = idx;
               hit_word_in = rd_word;
            end
            if (!cur_valid && !free_f_ff) begin
               free_f_in   = 1'b1;
               free_idx_in = idx;
            end
            if (cur_valid && cur_pin == '0) begin
               if (!unp_f_ff) begin
                  unp_f_in    = 1'b1;
                  unp_idx_in  = idx;
                  unp_word_in = rd_word;
               end
               if (!rd_word[ACC_B] && !clr_f_ff) begin
                  clr_f_in    = 1'b1;
                  clr_idx_in  = idx;
                  clr_word_in = rd_word;
               end
            end
            if (idx_last) begin
               state_in = S_DECIDE;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_LK_RD;
            end
         end
         S_DECIDE: begin
            if (out_free) begin
               out_v_in    = 1'b1;
               out_last_in = 1'b1;
               out_in      = '0;
               state_in    = S_IDLE;
               priority if (hit_f_ff) begin
                  vword = hit_word_ff;
                  if (vword[DRT_B-1:PIN_LO] != '1) begin
                     vword[DRT_B-1:PIN_LO] = vword[DRT_B-1:PIN_LO] + PIN_BITS'(1);
                  end
                  vword[ACC_B] = 1'b1;
                  vword[DRT_B] = vword[DRT_B] | wr_ff;
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = hit_idx_ff;
                  ram_wr_data = vword;
                  out_in.entry_index = OUT_IDX_W'(hit_idx_ff);
                  out_in.hit         = 1'b1;
               end else if (free_f_ff) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = free_idx_ff;
                  ram_wr_data = {1'b1, wr_ff, PIN_BITS'(1), sector_ff};
                  valid_in[free_idx_ff] = 1'b1;
                  out_in.entry_index = OUT_IDX_W'(free_idx_ff);
                  out_in.fill_valid  = 1'b1;
                  out_in.fill_sector = sector_ff;
               end else if (!unp_f_ff) begin
                  out_in.no_victim = 1'b1;
               end else begin
                  vword       = clr_f_ff ? clr_word_ff : unp_word_ff;
                  victim_in   = clr_f_ff ? clr_idx_ff : unp_idx_ff;
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = victim_in;
                  ram_wr_data = {1'b1, wr_ff, PIN_BITS'(1), sector_ff};
                  out_in.entry_index = OUT_IDX_W'(victim_in);
                  out_in.fill_valid  = 1'b1;
                  out_in.fill_sector = sector_ff;
                  if (vword[DRT_B]) begin
                     out_in.writeback_valid  = 1'b1;
                     out_in.writeback_sector = vword[TAG_W-1:0];
                  end
                  // second chance: clear marks passed over before the victim
                  limit_in = clr_f_ff ? CW'(clr_idx_ff) : CW'(ENTRIES);
                  idx_in   = '0;
                  state_in = S_CS_RD;
               end
            end
         end
         S_CS_RD: begin
            if (idx_ff == limit_ff) begin
               state_in = S_IDLE;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = S_CS_EV;
            end
         end
         S_CS_EV: begin
            if (idx != victim_ff && cur_pin == '0 && rd_word[ACC_B]) begin
               vword        = rd_word;
               vword[ACC_B] = 1'b0;
               ram_wr_en    = 1'b1;
               ram_wr_data  = vword;
            end
            idx_in   = idx_ff + CW'(1);
            state_in = S_CS_RD;
         end
         S_REL_EV: begin
            if (valid_ff[rel_ff] && cur_pin != '0) begin
               vword = rd_word;
               vword[DRT_B-1:PIN_LO] = cur_pin - PIN_BITS'(1);
               ram_wr_en   = 1'b1;
               ram_wr_addr = rel_ff;
               ram_wr_data = vword;
            end
            state_in = S_IDLE;
         end
         S_FL_RD: begin
            ram_rd_en = 1'b1;
            state_in  = S_FL_EV;
         end
         S_FL_EV: begin
            if (cur_valid && rd_word[DRT_B] && pend_v_ff && !out_free) begin
               state_in = S_FL_EV;
            end else begin
               if (cur_valid && rd_word[DRT_B]) begin
                  if (pend_v_ff) begin
                     out_v_in    = 1'b1;
                     out_last_in = 1'b0;
                     out_in      = '0;
                     out_in.entry_index      = OUT_IDX_W'(pend_idx_ff);
                     out_in.writeback_valid  = 1'b1;
                     out_in.writeback_sector = pend_tag_ff;
                  end
                  pend_v_in   = 1'b1;
                  pend_idx_in = idx;
                  pend_tag_in = rd_word[TAG_W-1:0];
                  vword        = rd_word;
                  vword[DRT_B] = 1'b0;
                  ram_wr_en    = 1'b1;
                  ram_wr_data  = vword;
               end
               if (idx_last) begin
                  state_in = S_FL_END;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_FL_RD;
               end
            end
         end
         S_FL_END: begin
            if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  out_v_in    = 1'b1;
                  out_last_in = 1'b1;
                  out_in      = '0;
                  out_in.entry_index      = OUT_IDX_W'(pend_idx_ff);
                  out_in.writeback_valid  = 1'b1;
                  out_in.writeback_sector = pend_tag_ff;
               end
               pend_v_in = 1'b0;
               if (clear_ff) begin
                  valid_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         out_v_ff  <= 1'b0;
         valid_ff  <= '0;
         pend_v_ff <= 1'b0;
         hit_f_ff  <= 1'b0;
         free_f_ff <= 1'b0;
         unp_f_ff  <= 1'b0;
         clr_f_ff  <= 1'b0;
         idx_ff    <= '0;
         limit_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         out_v_ff  <= out_v_in;
         valid_ff  <= valid_in;
         pend_v_ff <= pend_v_in;
         hit_f_ff  <= hit_f_in;
         free_f_ff <= free_f_in;
         unp_f_ff  <= unp_f_in;
         clr_f_ff  <= clr_f_in;
         idx_ff    <= idx_in;
         limit_ff  <= limit_in;
      end
      sector_ff   <= sector_in;
      wr_ff       <= wr_in;
      clear_ff    <= clear_in;
      rel_ff      <= rel_in;
      hit_idx_ff  <= hit_idx_in;
      hit_word_ff <= hit_word_in;
      free_idx_ff <= free_idx_in;
      unp_idx_ff  <= unp_idx_in;
      unp_word_ff <= unp_word_in;
      clr_idx_ff  <= clr_idx_in;
      clr_word_ff <= clr_word_in;
      victim_ff   <= victim_in;
      pend_idx_ff <= pend_idx_in;
      pend_tag_ff <= pend_tag_in;
      out_last_ff <= out_last_in;
      out_ff      <= out_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {6'b0, out_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

[dv/sector_cache_clock_tags_checker.sv]
module sector_cache_clock_tags_checker
   import scct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending,
   output int          beats_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_ENTRIES = 64;
   localparam logic [7:0] PIN_CEIL = 8'hff;

   typedef struct packed {
      logic    last;
      rsp_type f;
   } cache_beat_type;

   logic        line_valid [NUM_ENTRIES];
   logic [31:0] line_tag   [NUM_ENTRIES];
   logic [7:0]  line_pin   [NUM_ENTRIES];
   logic        line_dirty [NUM_ENTRIES];
   logic        line_ref   [NUM_ENTRIES];
   cache_beat_type owed_beats [$];

   function automatic cache_beat_type make_beat(int idx, logic hit, logic fv, logic [31:0] fs,
                                                logic wv, logic [31:0] ws, logic nv,
                                                logic last);
      cache_beat_type b;
      b.f.entry_index      = idx[5:0];
      b.f.hit              = hit;
      b.f.fill_valid       = fv;
      b.f.fill_sector      = fs;
      b.f.writeback_valid  = wv;
      b.f.writeback_sector = ws;
      b.f.no_victim        = nv;
      b.last               = last;
      return b;
   endfunction

   task automatic lookup_or_fill(input logic [31:0] sector, input logic wr);
      int victim;
      logic free_pin;
      logic wv;
      logic [31:0] ws;
      victim   = -1;
      free_pin = 1'b0;
      wv       = 1'b0;
      ws       = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (line_valid[i] && line_tag[i] == sector) begin
            if (line_pin[i] != PIN_CEIL) line_pin[i]++;
            line_ref[i]   = 1'b1;
            line_dirty[i] = line_dirty[i] | wr;
            owed_beats.push_back(make_beat(i, 1'b1, 1'b0, '0, 1'b0, '0, 1'b0, 1'b1));
            return;
         end
      end
      for (int i = 0; i < NUM_ENTRIES; i++)
         if (victim < 0 && !line_valid[i]) victim = i;
      if (victim < 0) begin
         for (int i = 0; i < NUM_ENTRIES; i++)
            if (line_pin[i] == 0) free_pin = 1'b1;
         if (!free_pin) begin
            owed_beats.push_back(make_beat(0, 1'b0, 1'b0, '0, 1'b0, '0, 1'b1, 1'b1));
            return;
         end
         // second chance: clear marks until an unmarked, unpinned line turns up
         for (int i = 0; i < NUM_ENTRIES && victim < 0; i++) begin
            if (line_pin[i] == 0) begin
               if (line_ref[i]) line_ref[i] = 1'b0;
               else victim = i;
            end
         end
         for (int i = 0; i < NUM_ENTRIES && victim < 0; i++)
            if (line_pin[i] == 0) victim = i;
         if (line_dirty[victim]) begin
            wv = 1'b1;
            ws = line_tag[victim];
         end
      end
      line_valid[victim] = 1'b1;
      line_tag[victim]   = sector;
      line_pin[victim]   = 8'd1;
      line_ref[victim]   = 1'b1;
      line_dirty[victim] = wr;
      owed_beats.push_back(make_beat(victim, 1'b0, 1'b1, sector, wv, ws, 1'b0, 1'b1));
   endtask

   task automatic flush_lines(input logic clear_all);
      int last_pos;
      last_pos = -1;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (line_valid[i] && line_dirty[i]) begin
            owed_beats.push_back(make_beat(i, 1'b0, 1'b0, '0, 1'b1, line_tag[i], 1'b0,
                                           1'b0));
            last_pos = owed_beats.size() - 1;
         end
         line_dirty[i] = 1'b0;
         if (clear_all) begin
            line_valid[i] = 1'b0;
            line_pin[i]   = '0;
            line_ref[i]   = 1'b0;
         end
      end
      if (last_pos >= 0) owed_beats[last_pos].last = 1'b1;
   endtask

   always @(posedge clock) begin
      cache_beat_type want;
      rsp_type        got;
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
            line_pin[i]   = '0;
            line_dirty[i] = 1'b0;
            line_ref[i]   = 1'b0;
         end
         owed_beats.delete();
      end else begin
         // check the result beat first: it always belongs to an older request
         if (rsp_tvalid && rsp_tready) begin
            beats_seen++;
            got = rsp_type'(rsp_tdata[73:0]);
            if (owed_beats.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result beat %h last %b", $realtime, rsp_tdata,
                           rsp_tlast);
            end else begin
               want = owed_beats.pop_front();
               if (got.entry_index !== want.f.entry_index || got.hit !== want.f.hit ||
                   got.fill_valid !== want.f.fill_valid ||
                   got.fill_sector !== want.f.fill_sector ||
                   got.writeback_valid !== want.f.writeback_valid ||
                   got.writeback_sector !== want.f.writeback_sector ||
                   got.no_victim !== want.f.no_victim || rsp_tlast !== want.last ||
                   rsp_tdata[79:74] !== 6'd0) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch idx/hit/fv/fs/wv/ws/nv/last expected ",
                               "%0d %b %b %h %b %h %b %b got %0d %b %b %h %b %h %b %b"},
                              $realtime, want.f.entry_index, want.f.hit, want.f.fill_valid,
                              want.f.fill_sector, want.f.writeback_valid,
                              want.f.writeback_sector, want.f.no_victim, want.last,
                              got.entry_index, got.hit, got.fill_valid, got.fill_sector,
                              got.writeback_valid, got.writeback_sector, got.no_victim,
                              rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               KIND_ACCESS: lookup_or_fill(req_tdata[31:0], req_tdata[32]);
               KIND_RELEASE: begin
                  if (line_pin[req_tdata[38:33]] != 0) line_pin[req_tdata[38:33]]--;
               end
               KIND_FLUSH:       flush_lines(1'b0);
               KIND_FLUSH_CLEAR: flush_lines(1'b1);
               default: ;
            endcase
         end
      end
      pending = owed_beats.size();
   end

   initial begin
      fail_count = 0;
      pending    = 0;
      beats_seen = 0;
   end

endmodule

[dv/sector_cache_clock_tags_core_test.sv]
module sector_cache_clock_tags_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import scct_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   logic        rsp_tlast;
   int          fail_count;
   int          pending;
   int          beats_seen;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          sent;
   logic [31:0] sector_base;

   sector_cache_clock_tags_core dut (.*);

   sector_cache_clock_tags_checker scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("sector_cache_clock_tags_core test failed");
      $finish;
   end

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   task automatic send_req(input logic [1:0] kind, input logic [31:0] sector,
                           input logic wr, input logic [5:0] rel);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, rel, wr, sector};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic random_req();
      int pick;
      logic [31:0] sector;
      pick   = $urandom_range(99);
      sector = ($urandom_range(99) < 85) ? sector_base + $urandom_range(79) : $urandom();
      if (pick < 52)      send_req(KIND_ACCESS, sector, 1'($urandom_range(1)),
                                   6'($urandom()));
      else if (pick < 88) send_req(KIND_RELEASE, $urandom(), 1'($urandom_range(1)),
                                   6'($urandom_range(63)));
      else if (pick < 96) send_req(KIND_FLUSH, $urandom(), 1'($urandom_range(1)),
                                   6'($urandom()));
      else                send_req(KIND_FLUSH_CLEAR, $urandom(), 1'($urandom_range(1)),
                                   6'($urandom()));
   endtask

   initial begin
      int waited;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = KIND_ACCESS;
      rsp_tready     = 1'b0;
      send_idle_pct  = 24;
      recv_stall_pct = 46;
      sent           = 0;
      sector_base    = $urandom();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, hit and dirty merge, releases, both flushes on a nearly empty table
      send_req(KIND_FLUSH, '0, 1'b0, '0);
      send_req(KIND_ACCESS, 32'h0000_0000, 1'b0, '0);
      send_req(KIND_ACCESS, 32'hffff_ffff, 1'b1, 6'h3f);
      send_req(KIND_ACCESS, 32'h0000_0000, 1'b1, '0);
      send_req(KIND_ACCESS, 32'hffff_ffff, 1'b0, '0);
      send_req(KIND_RELEASE, '0, 1'b0, 6'd0);
      send_req(KIND_RELEASE, '0, 1'b0, 6'd0);
      send_req(KIND_RELEASE, '0, 1'b0, 6'd0);
      send_req(KIND_RELEASE, 32'hffff_ffff, 1'b1, 6'h3f);
      send_req(KIND_ACCESS, 32'h5555_aaaa, 1'b1, '0);
      send_req(KIND_FLUSH, '0, 1'b0, '0);
      send_req(KIND_FLUSH, '0, 1'b0, '0);
      send_req(KIND_ACCESS, 32'haaaa_5555, 1'b1, '0);
      send_req(KIND_FLUSH_CLEAR, '0, 1'b1, 6'h3f);
      send_req(KIND_ACCESS, 32'hffff_ffff, 1'b0, '0);
      send_req(KIND_FLUSH_CLEAR, '0, 1'b0, '0);

      // bursts of requests over a small sector pool fill the table and force the clock walk
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct  = (phase == 0) ? 24 : (phase == 1) ? 46 : 0;
         recv_stall_pct = (phase == 0) ? 46 : (phase == 1) ? 24 : 0;
         for (int n = 0; n < 135; n++) random_req();
      end
      req_tvalid <= 1'b0;

      waited = 0;
      while (pending != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (600) @(posedge clock);

      $display("Covered %0d requests (hits, fills, clock evictions, pinned misses, flushes);",
               sent);
      $display("checked %0d result beats with %0d still owed.", beats_seen, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("sector_cache_clock_tags_core test passed");
      end else begin
         $display("sector_cache_clock_tags_core test failed");
      end
      $finish;
   end

endmodule
